@@ hw/rtl/ates_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ates_pkg;

  localparam int SAMPLES_DEFAULT = 10;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 14;
  localparam int COUNT_W  = 4;
  localparam int MV_W     = 11;
  localparam int TEMP_W   = 10;
  localparam int SEG_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DP_ENABLE = 2'd1;

  localparam logic [MV_W-1:0] OFFSET_RESET = 11'd500;
  localparam logic            DP_RESET     = 1'b1;
  localparam logic [SEG_W-1:0] DP_BIT      = 8'b0100_0000;

  typedef struct packed {
    logic [MV_W-1:0] offset_mv;
    logic            dp_enable;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  function automatic logic [SEG_W-1:0] seg_tenths(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'hBE;
      4'd1: s = 8'h18;
      4'd2: s = 8'hD6;
      4'd3: s = 8'hDC;
      4'd4: s = 8'h78;
      4'd5: s = 8'hEC;
      4'd6: s = 8'hEE;
      4'd7: s = 8'h98;
      4'd8: s = 8'hFE;
      4'd9: s = 8'hFC;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [SEG_W-1:0] seg_ones(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'hBE;
      4'd1: s = 8'h90;
      4'd2: s = 8'hAB;
      4'd3: s = 8'hB9;
      4'd4: s = 8'h95;
      4'd5: s = 8'h3D;
      4'd6: s = 8'h3F;
      4'd7: s = 8'hB0;
      4'd8: s = 8'hBF;
      4'd9: s = 8'hBD;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [SEG_W-1:0] seg_tens(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'hEE;
      4'd1: s = 8'h82;
      4'd2: s = 8'h76;
      4'd3: s = 8'hD6;
      4'd4: s = 8'h9A;
      4'd5: s = 8'hDC;
      4'd6: s = 8'hFC;
      4'd7: s = 8'h86;
      4'd8: s = 8'hFE;
      4'd9: s = 8'hDE;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ates_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ates_front #(
  parameter int SAMPLES = ates_pkg::SAMPLES_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ates_pkg::SAMPLE_W-1:0] adc_sample,
  input  wire ates_pkg::q_status_t           q_status,
  output logic                               push,
  output logic [ates_pkg::SUM_W-1:0]         push_sum
);

  localparam logic [ates_pkg::COUNT_W-1:0] BATCH = ates_pkg::COUNT_W'(SAMPLES);

  logic [ates_pkg::SUM_W-1:0]   sample_sum;
  logic [ates_pkg::COUNT_W-1:0] samples_taken;
  logic [ates_pkg::SUM_W-1:0]   sum_next;
  logic [ates_pkg::COUNT_W-1:0] count_next;
  logic                         batch_done;
  logic                         accept;

  assign sum_next   = sample_sum + ates_pkg::SUM_W'(adc_sample);
  assign count_next = samples_taken + 1'b1;
  assign batch_done = (count_next == BATCH);
  assign in_ready   = !batch_done || !q_status.full;
  assign accept     = in_valid && in_ready;
  assign push       = accept && batch_done;
  assign push_sum   = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      samples_taken <= '0;
    end else if (accept) begin
      if (batch_done) begin
        sample_sum    <= '0;
        samples_taken <= '0;
      end else begin
        sample_sum    <= sum_next;
        samples_taken <= count_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ates_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ates_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [ates_pkg::SUM_W-1:0] push_sum,
  input  wire logic                       pop,
  output logic [ates_pkg::SUM_W-1:0]      pop_sum,
  output ates_pkg::q_status_t             status
);

  logic [ates_pkg::SUM_W-1:0] entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign pop_sum          = entry[rd_ptr];
  assign status.full      = (count == 2'd2);
  assign status.not_empty = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ates_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ates_back #(
  parameter int SAMPLES = ates_pkg::SAMPLES_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ates_pkg::cfg_t             cfg,
  input  wire logic                       q_valid,
  input  wire logic [ates_pkg::SUM_W-1:0] q_sum,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [ates_pkg::SEG_W-1:0]      tens_segments,
  output logic [ates_pkg::SEG_W-1:0]      ones_segments,
  output logic [ates_pkg::SEG_W-1:0]      tenths_segments,
  output logic [ates_pkg::MV_W-1:0]       averaged_millivolts,
  output logic [ates_pkg::TEMP_W-1:0]     tenths_of_degree,
  output logic                            below_zero
);

  localparam int SUM_W   = ates_pkg::SUM_W;
  localparam int MV_W    = ates_pkg::MV_W;
  localparam int TEMP_W  = ates_pkg::TEMP_W;
  localparam int SHIFT   = SUM_W + 4;
  localparam int MULT_W  = SHIFT + 1;
  localparam int PROD_W  = SUM_W + MULT_W;
  localparam int REM_W   = SHIFT;
  localparam logic [MULT_W-1:0] RECIP = MULT_W'((64'd1 << SHIFT) / SAMPLES);
  localparam logic [REM_W-1:0]  DIV   = REM_W'(SAMPLES);

  logic                   advance;
  logic                   v1, v2, v3, v4;

  logic [PROD_W-1:0]      s1_prod;
  logic [SUM_W-1:0]       s1_sum;

  logic [MV_W-1:0]        s2_mv;

  logic [MV_W-1:0]        s3_mv;
  logic [TEMP_W-1:0]      s3_temp;
  logic                   s3_below;

  logic [MV_W-1:0]        s4_mv;
  logic [TEMP_W-1:0]      s4_temp;
  logic                   s4_below;
  logic [3:0]             s4_tens;
  logic [6:0]             s4_rem;

  logic [SUM_W-1:0]       q_est;
  logic [REM_W-1:0]       div_rem;
  logic [SUM_W-1:0]       quot;
  logic [MV_W-1:0]        diff;
  logic [15:0]            tens_prod;
  logic [3:0]             tens_d;
  logic [TEMP_W-1:0]      rem_wide;
  logic [14:0]            ones_prod;
  logic [3:0]             ones_d;
  logic [6:0]             tenths_wide;
  logic [ates_pkg::SEG_W-1:0] ones_seg;

  assign advance = !out_valid || out_ready;
  assign pop     = advance && q_valid;

  assign q_est   = s1_prod[SHIFT +: SUM_W];
  assign div_rem = REM_W'(s1_sum) - REM_W'(q_est) * DIV;
  assign quot    = q_est + SUM_W'(div_rem >= DIV);

  assign diff    = s2_mv - cfg.offset_mv;

  assign tens_prod = 16'(s3_temp) * 16'd41;
  assign tens_d    = tens_prod[15:12];
  assign rem_wide  = s3_temp - TEMP_W'(tens_d) * TEMP_W'(100);

  assign ones_prod   = 15'(s4_rem) * 15'd205;
  assign ones_d      = ones_prod[14:11];
  assign tenths_wide = s4_rem - 7'(ones_d) * 7'd10;
  assign ones_seg    = ates_pkg::seg_ones(ones_d) | (cfg.dp_enable ? ates_pkg::DP_BIT : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= q_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prod <= PROD_W'(q_sum) * PROD_W'(RECIP);
      s1_sum  <= q_sum;

      s2_mv <= {quot[MV_W-2:0], 1'b0};

      s3_mv    <= s2_mv;
      s3_below <= (s2_mv < cfg.offset_mv);
      if (s2_mv < cfg.offset_mv) begin
        s3_temp <= '0;
      end else if (diff >= MV_W'(2000)) begin
        s3_temp <= TEMP_W'(diff - MV_W'(2000));
      end else if (diff >= MV_W'(1000)) begin
        s3_temp <= TEMP_W'(diff - MV_W'(1000));
      end else begin
        s3_temp <= TEMP_W'(diff);
      end

      s4_mv    <= s3_mv;
      s4_temp  <= s3_temp;
      s4_below <= s3_below;
      s4_tens  <= tens_d;
      s4_rem   <= rem_wide[6:0];

      averaged_millivolts <= s4_mv;
      tenths_of_degree    <= s4_temp;
      below_zero          <= s4_below;
      tens_segments       <= ates_pkg::seg_tens(s4_tens);
      ones_segments       <= ones_seg;
      tenths_segments     <= ates_pkg::seg_tenths(tenths_wide[3:0]);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/averaged_temperature_segment_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// in        in_valid / in_ready     adc_sample
// out       out_valid / out_ready   tens_segments, ones_segments, tenths_segments,
//                                   averaged_millivolts, tenths_of_degree, below_zero
// cfg       cfg_we                  cfg_index, cfg_data
//
// One sample is accepted every cycle unless it completes a batch while the queue is full;
// each batch of SAMPLES samples yields one frame. Batch sums pass through the two-entry
// queue into the five-stage divide and digit pipeline; frames can follow one another on
// every cycle while the output is ready, and a stalled output holds the whole pipeline.
// Reset is synchronous and clears the sum, the count, the queue and all valid flags.

module averaged_temperature_segment_encoder #(
  parameter int SAMPLES = ates_pkg::SAMPLES_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ates_pkg::SAMPLE_W-1:0]     adc_sample,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [ates_pkg::SEG_W-1:0]             tens_segments,
  output logic [ates_pkg::SEG_W-1:0]             ones_segments,
  output logic [ates_pkg::SEG_W-1:0]             tenths_segments,
  output logic [ates_pkg::MV_W-1:0]              averaged_millivolts,
  output logic [ates_pkg::TEMP_W-1:0]            tenths_of_degree,
  output logic                                   below_zero,
  input  wire logic                              cfg_we,
  input  wire logic [ates_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ates_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ates_pkg::cfg_t      cfg;
  ates_pkg::q_status_t q_status;
  logic                       push;
  logic [ates_pkg::SUM_W-1:0] push_sum;
  logic                       pop;
  logic [ates_pkg::SUM_W-1:0] pop_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_mv <= ates_pkg::OFFSET_RESET;
      cfg.dp_enable <= ates_pkg::DP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ates_pkg::REG_OFFSET_MV: cfg.offset_mv <= cfg_data[ates_pkg::MV_W-1:0];
        ates_pkg::REG_DP_ENABLE: cfg.dp_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ates_front #(
    .SAMPLES(SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .adc_sample(adc_sample),
    .q_status  (q_status),
    .push      (push),
    .push_sum  (push_sum)
  );

  ates_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_sum(push_sum),
    .pop     (pop),
    .pop_sum (pop_sum),
    .status  (q_status)
  );

  ates_back #(
    .SAMPLES(SAMPLES)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .q_valid            (q_status.not_empty),
    .q_sum              (pop_sum),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .tens_segments      (tens_segments),
    .ones_segments      (ones_segments),
    .tenths_segments    (tenths_segments),
    .averaged_millivolts(averaged_millivolts),
    .tenths_of_degree   (tenths_of_degree),
    .below_zero         (below_zero)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full && !pop))
    else $error("Batch sum pushed into a full queue.");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_status.not_empty)
    else $error("Queue popped while empty.");

  a_below_zero_clamps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && below_zero) |-> (tenths_of_degree == '0))
    else $error("Negative temperature was not clamped to zero.");

  a_temp_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tenths_of_degree < ates_pkg::TEMP_W'(1000)))
    else $error("Displayed temperature is out of range.");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

endmodule

`default_nettype wire

@@ test/ates_frame_checker.sv @@
`timescale 1ns / 1ps

module ates_frame_checker
  import ates_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   adc_sample,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [SEG_W-1:0]      tens_segments,
  input  logic [SEG_W-1:0]      ones_segments,
  input  logic [SEG_W-1:0]      tenths_segments,
  input  logic [MV_W-1:0]       averaged_millivolts,
  input  logic [TEMP_W-1:0]     tenths_of_degree,
  input  logic                  below_zero,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    frames_pending
);

  typedef struct packed {
    logic [SEG_W-1:0]  tens;
    logic [SEG_W-1:0]  ones;
    logic [SEG_W-1:0]  tenths;
    logic [MV_W-1:0]   mv;
    logic [TEMP_W-1:0] temp;
    logic              below;
  } frame_t;

  // Digit d of each table sits at element d.
  localparam logic [9:0][SEG_W-1:0] TENTHS_GLYPH = {
    8'hFC, 8'hFE, 8'h98, 8'hEE, 8'hEC, 8'h78, 8'hDC, 8'hD6, 8'h18, 8'hBE
  };
  localparam logic [9:0][SEG_W-1:0] ONES_GLYPH = {
    8'hBD, 8'hBF, 8'hB0, 8'h3F, 8'h3D, 8'h95, 8'hB9, 8'hAB, 8'h90, 8'hBE
  };
  localparam logic [9:0][SEG_W-1:0] TENS_GLYPH = {
    8'hDE, 8'hFE, 8'h86, 8'hFC, 8'hDC, 8'h9A, 8'hD6, 8'h76, 8'h82, 8'hEE
  };

  logic [SUM_W-1:0]   batch_sum;
  logic [COUNT_W-1:0] batch_count;
  cfg_t               cfg;
  frame_t             frames_due[$];
  frame_t             seen;
  frame_t             want;

  function automatic frame_t display_frame_for(input logic [SUM_W-1:0] sum, input cfg_t c);
    frame_t      f;
    int unsigned mv;
    int unsigned t;
    mv = ((int'(sum) / SAMPLES) * 2) & 32'h7FF;
    if (mv < c.offset_mv) begin
      t = 0;
      f.below = 1'b1;
    end else begin
      t = (mv - c.offset_mv) % 1000;
      f.below = 1'b0;
    end
    f.mv     = MV_W'(mv);
    f.temp   = TEMP_W'(t);
    f.tens   = TENS_GLYPH[(t / 100) % 10];
    f.ones   = ONES_GLYPH[(t / 10) % 10] | (c.dp_enable ? DP_BIT : '0);
    f.tenths = TENTHS_GLYPH[t % 10];
    return f;
  endfunction

  task automatic compare(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      batch_sum      = '0;
      batch_count    = '0;
      cfg.offset_mv  = OFFSET_RESET;
      cfg.dp_enable  = DP_RESET;
      mismatch_count = 0;
      frames_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = '{tens_segments, ones_segments, tenths_segments,
                 averaged_millivolts, tenths_of_degree, below_zero};
        if (frames_due.size() == 0) begin
          $error("Output transaction with no frame expected: tenths_of_degree %0d",
                 tenths_of_degree);
          mismatch_count++;
        end else begin
          want = frames_due.pop_front();
          compare("tens_segments", want.tens, seen.tens);
          compare("ones_segments", want.ones, seen.ones);
          compare("tenths_segments", want.tenths, seen.tenths);
          compare("averaged_millivolts", want.mv, seen.mv);
          compare("tenths_of_degree", want.temp, seen.temp);
          compare("below_zero", want.below, seen.below);
        end
      end
      if (in_valid && in_ready) begin
        batch_sum   = batch_sum + adc_sample;
        batch_count = batch_count + 1'b1;
        if (batch_count == SAMPLES) begin
          frames_due.push_back(display_frame_for(batch_sum, cfg));
          batch_sum   = '0;
          batch_count = '0;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET_MV: cfg.offset_mv = cfg_data;
          REG_DP_ENABLE: cfg.dp_enable = cfg_data[0];
          default: ;
        endcase
      end
    end
    frames_pending = frames_due.size();
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import ates_pkg::*;

  localparam int SAMPLES       = SAMPLES_DEFAULT;
  localparam int PHASES        = 12;
  localparam int BATCHES       = 15;
  localparam int PIPE_SETTLE   = 12;
  localparam int TAIL_CYCLES   = 20;
  localparam int QUIET_LIMIT   = 1000;
  localparam int MODE_STEADY   = 0;
  localparam int MODE_SRC_IDLE = 1;
  localparam int MODE_SNK_STALL = 2;
  localparam int MODE_BOTH     = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   adc_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SEG_W-1:0]      tens_segments;
  logic [SEG_W-1:0]      ones_segments;
  logic [SEG_W-1:0]      tenths_segments;
  logic [MV_W-1:0]       averaged_millivolts;
  logic [TEMP_W-1:0]     tenths_of_degree;
  logic                  below_zero;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatch_count;
  int frames_pending;
  int gap_pct = 0;
  int stall_pct = 0;
  int cur_offset = OFFSET_RESET;
  int quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  averaged_temperature_segment_encoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .adc_sample(adc_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .tens_segments(tens_segments), .ones_segments(ones_segments),
    .tenths_segments(tenths_segments), .averaged_millivolts(averaged_millivolts),
    .tenths_of_degree(tenths_of_degree), .below_zero(below_zero),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ates_frame_checker #(.SAMPLES(SAMPLES)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .adc_sample(adc_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .tens_segments(tens_segments), .ones_segments(ones_segments),
    .tenths_segments(tenths_segments), .averaged_millivolts(averaged_millivolts),
    .tenths_of_degree(tenths_of_degree), .below_zero(below_zero),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .frames_pending(frames_pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Most batches cluster around one level so that the average sweeps the whole
  // range; some sit on the offset to straddle the zero crossing.
  task automatic send_batch;
    int center;
    int spread;
    int v;
    if ($urandom_range(0, 9) < 2) begin
      center = cur_offset / 2 + $urandom_range(0, 4) - 2;
    end else begin
      center = $urandom_range(0, 1023);
    end
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 4;
      2: spread = 64;
      default: spread = -1;
    endcase
    for (int i = 0; i < SAMPLES; i++) begin
      if (spread < 0) begin
        v = $urandom_range(0, 1023);
      end else begin
        v = center + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
      end
      send_sample(SAMPLE_W'(v));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    do @(negedge clk); while (frames_pending != 0);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  initial begin
    int offset;
    int dp;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    cfg_we <= 1'b0;
    repeat (SAMPLES) send_sample('1);
    repeat (SAMPLES) send_sample('0);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin offset = 0;    dp = 0; end
        1: begin offset = 2047; dp = 1; end
        2: begin offset = 500;  dp = 1; end
        3: begin offset = 1;    dp = 0; end
        4: begin offset = 2046; dp = 1; end
        default: begin
          offset = $urandom_range(0, 1400);
          dp     = $urandom_range(0, 1);
        end
      endcase
      cur_offset = offset;
      write_reg(REG_OFFSET_MV, CFG_DATA_W'(offset));
      write_reg(REG_DP_ENABLE, CFG_DATA_W'(dp));
      if (phase % 3 == 2) write_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 2047)));
      cfg_we <= 1'b0;

      case (phase % 4)
        MODE_STEADY:    begin gap_pct = 0;  stall_pct = 0;  end
        MODE_SRC_IDLE:  begin gap_pct = 62; stall_pct = 0;  end
        MODE_SNK_STALL: begin gap_pct = 0;  stall_pct = 62; end
        MODE_BOTH:      begin gap_pct = 8;  stall_pct = 8;  end
        default: ;
      endcase
      repeat (BATCHES) send_batch();
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ates_pkg.sv
hw/rtl/ates_front.sv
hw/rtl/ates_queue.sv
hw/rtl/ates_back.sv
hw/rtl/averaged_temperature_segment_encoder.sv
test/ates_frame_checker.sv
test/tb.sv
